[hw/rtl/assert_macros.svh]
// Assertion macros shared by the scanline offset generator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is held.
`define SOSG_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define SOSG_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[hw/rtl/sosg_pkg.sv]
// Package with the types, constants and sine table of the scanline offset generator.
package sosg_pkg;

    // Quarter-wave table geometry.
    localparam int unsigned QTAB_BITS = 8;
    localparam int unsigned QTAB_N    = 1 << QTAB_BITS;
    localparam int unsigned QTAB_AW   = QTAB_BITS + 1;

    // Half pi in Q30.
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    // Data widths.
    localparam int unsigned DATA_W = 16;
    localparam int unsigned LINE_W = 8;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_AMPLITUDE  = 2'd0,
        REG_TIME_STEP  = 2'd1,
        REG_LINE_SPEED = 2'd2,
        REG_WAVE_MODE  = 2'd3
    } t_reg_idx;

    // Wave shaping modes; the unused code behaves as plain sine.
    typedef enum logic [1:0] {
        MODE_SINE  = 2'd0,
        MODE_CLAMP = 2'd1,
        MODE_ABS   = 2'd2
    } t_wave_mode;

    // Request sequencer states.
    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_READ = 2'd1,
        S_MUL  = 2'd2,
        S_DONE = 2'd3
    } t_state;

    typedef logic [DATA_W-1:0] t_sine_tab [0:QTAB_N];

    // One table entry: Taylor series of sin in Q30, rounded to Q1.15 and capped.
    function automatic logic [DATA_W-1:0] sine_entry(input int unsigned k);
        longint unsigned theta;
        longint unsigned theta2;
        longint unsigned term;
        longint          sum;
        longint unsigned q;
        theta  = (longint'(k) * HALF_PI_Q30) >> QTAB_BITS;
        theta2 = (theta * theta) >> 30;
        term   = theta;
        sum    = longint'(theta);
        term   = ((term * theta2) >> 30) / 6;
        sum    = sum - longint'(term);
        term   = ((term * theta2) >> 30) / 20;
        sum    = sum + longint'(term);
        term   = ((term * theta2) >> 30) / 42;
        sum    = sum - longint'(term);
        term   = ((term * theta2) >> 30) / 72;
        sum    = sum + longint'(term);
        term   = ((term * theta2) >> 30) / 110;
        sum    = sum - longint'(term);
        term   = ((term * theta2) >> 30) / 156;
        sum    = sum + longint'(term);
        term   = ((term * theta2) >> 30) / 210;
        sum    = sum - longint'(term);
        if (sum < 0) begin
            sum = 0;
        end
        q = ((longint'(sum) * 32767) + (64'd1 << 29)) >> 30;
        if (q > 64'd32767) begin
            q = 64'd32767;
        end
        return q[DATA_W-1:0];
    endfunction

    // Whole quarter-wave table, built at elaboration.
    function automatic t_sine_tab build_sine_tab();
        t_sine_tab tab;
        for (int unsigned k = 0; k <= QTAB_N; k++) begin
            tab[k] = sine_entry(k);
        end
        return tab;
    endfunction

endpackage

[hw/rtl/sosg_sine_rom.sv]
// Quarter-wave sine ROM with a registered read port.
module sosg_sine_rom
    import sosg_pkg::*;
(
    input  logic               i_clk,
    input  logic [QTAB_AW-1:0] i_addr,
    output logic [DATA_W-1:0]  o_data
);

    localparam t_sine_tab SINE_ROM = build_sine_tab();

    logic [DATA_W-1:0] r_data;

    // Synchronous read into a data register.
    always_ff @(posedge i_clk) begin
        r_data <= SINE_ROM[i_addr];
    end

    assign o_data = r_data;

endmodule

[hw/rtl/sosg_shape.sv]
// Rounding of the Q1.15 product and wave mode shaping.
module sosg_shape
    import sosg_pkg::*;
(
    input  logic signed [2*DATA_W-1:0] i_prod,
    input  logic        [1:0]          i_mode,
    output logic        [DATA_W-1:0]   o_offset
);

    logic signed [2*DATA_W:0] w_sum;
    logic signed [DATA_W:0]   w_val;
    logic signed [DATA_W:0]   w_neg;

    // Round to nearest, ties toward plus infinity, then drop 15 fraction bits.
    assign w_sum = (2*DATA_W+1)'(i_prod) + (2*DATA_W+1)'(16384);
    assign w_val = $signed(w_sum[2*DATA_W-1:DATA_W-1]);
    assign w_neg = -w_val;

    // Apply the selected wave shape; the absolute value saturates at full scale.
    always_comb begin
        case (i_mode)
            MODE_CLAMP: begin
                o_offset = w_val[DATA_W] ? '0 : w_val[DATA_W-1:0];
            end
            MODE_ABS: begin
                if (!w_val[DATA_W-1]) begin
                    o_offset = w_val[DATA_W-1:0];
                end else if (w_neg[DATA_W-1]) begin
                    o_offset = {1'b0, {(DATA_W-1){1'b1}}};
                end else begin
                    o_offset = w_neg[DATA_W-1:0];
                end
            end
            default: begin
                o_offset = w_val[DATA_W-1:0];
            end
        endcase
    end

endmodule

[hw/rtl/scanline_sine_offset_generator_unit.sv]
// Top level of the scanline sine offset generator: sequencer, state and output register.
// A request walks in turn through the phase add, the sine ROM read, the multiply and the
// shaping step; the load into the output register waits while an earlier result is held.
// A new request is taken only in S_IDLE, after the previous one has been loaded.
// A finished result waits in the output register while the next request is taken.
// Reset (synchronous, active low) restores the register defaults and clears the phase.
module scanline_sine_offset_generator_unit
    import sosg_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_index,
    input  logic [DATA_W-1:0] i_cfg_data,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [LINE_W-1:0] i_line_index,
    input  logic              i_end_of_frame,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [DATA_W-1:0] o_offset,
    output logic [LINE_W-1:0] o_line_echo
);

`include "assert_macros.svh"

    t_state r_state, n_state;

    logic [DATA_W-1:0] r_amplitude;
    logic [DATA_W-1:0] r_time_step;
    logic [DATA_W-1:0] r_line_speed;
    logic [1:0]        r_wave_mode;
    logic [DATA_W-1:0] r_frame_phase;

    logic [DATA_W-1:0]          r_phase;
    logic [LINE_W-1:0]          r_line;
    logic                       r_eof;
    logic signed [2*DATA_W-1:0] r_prod;

    logic              r_out_valid;
    logic [DATA_W-1:0] r_offset;
    logic [LINE_W-1:0] r_line_echo;

    logic                     w_accept;
    logic                     w_load;
    logic                     w_phase_step;
    logic                     w_out_wait;
    logic [QTAB_BITS-1:0]     w_idx;
    logic [QTAB_AW-1:0]       w_addr;
    logic [DATA_W-1:0]        w_rom_data;
    logic signed [DATA_W-1:0] w_sine;
    logic [DATA_W-1:0]        w_shaped;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amplitude  <= DATA_W'(1802);
            r_time_step  <= DATA_W'(834);
            r_line_speed <= DATA_W'(1043);
            r_wave_mode  <= MODE_SINE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_AMPLITUDE:  r_amplitude  <= i_cfg_data;
                REG_TIME_STEP:  r_time_step  <= i_cfg_data;
                REG_LINE_SPEED: r_line_speed <= i_cfg_data;
                REG_WAVE_MODE:  r_wave_mode  <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // Sequencer state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and handshake decisions.
    always_comb begin
        n_state = r_state;
        o_ready = 1'b0;
        w_load  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_MUL;
            end
            S_MUL: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    w_load  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign w_accept     = i_valid && o_ready;
    assign w_phase_step = w_load && r_eof;
    assign w_out_wait   = (r_state == S_DONE) && r_out_valid;

    // Line phase for an accepted request.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_phase <= r_frame_phase + DATA_W'(r_line_speed * DATA_W'(i_line_index));
            r_line  <= i_line_index;
            r_eof   <= i_end_of_frame;
        end
    end

    // Quarter-wave folding of the phase into a table address.
    assign w_idx  = r_phase[DATA_W-3 -: QTAB_BITS];
    assign w_addr = r_phase[DATA_W-2] ? (QTAB_AW'(QTAB_N) - {1'b0, w_idx}) : {1'b0, w_idx};

    sosg_sine_rom u_rom (
        .i_clk  (i_clk),
        .i_addr (w_addr),
        .o_data (w_rom_data)
    );

    // Sign of the lower half turn and the amplitude product.
    assign w_sine = r_phase[DATA_W-1] ? -$signed(w_rom_data) : $signed(w_rom_data);

    always_ff @(posedge i_clk) begin
        if (r_state == S_MUL) begin
            r_prod <= (2*DATA_W)'(w_sine) * (2*DATA_W)'($signed(r_amplitude));
        end
    end

    sosg_shape u_shape (
        .i_prod   (r_prod),
        .i_mode   (r_wave_mode),
        .o_offset (w_shaped)
    );

    // Frame phase advances once the end-of-frame line has its result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_phase <= '0;
        end else if (w_phase_step) begin
            r_frame_phase <= r_frame_phase + r_time_step;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_offset    <= w_shaped;
            r_line_echo <= r_line;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_offset    = r_offset;
    assign o_line_echo = r_line_echo;

    // An accepted request always starts the table read.
    `SOSG_ASSERT(a_accept_starts_read, w_accept |=> (r_state == S_READ), "request not sequenced")
    // A waiting result is never overwritten.
    `SOSG_ASSERT(a_no_overwrite, (w_out_wait && !i_ready) |=> w_out_wait, "result overwritten")
    // The frame phase moves only when a result is loaded.
    `SOSG_ASSERT(a_phase_on_load, $changed(r_frame_phase) |-> $past(w_phase_step), "phase moved")

endmodule
